>>> rtl/sil_pkg.sv
// Shared types and constants for the sorted insert list.
`timescale 1ns / 1ps

package sil_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;

    // Commands from the controller to the entry row.
    typedef struct packed {
        logic insert;   // place the input value into the row
        logic rotate;   // move the listed head entry to the tail of the list
    } t_dp_cmd;

endpackage

>>> rtl/sil_datapath.sv
// Entry row of the sorted insert list: parallel insert and list rotation.
`timescale 1ns / 1ps

module sil_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sil_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [sil_pkg::VALUE_W-1:0]   i_value,
    output logic [$clog2(CAPACITY+1)-1:0]        o_count,
    output logic signed [sil_pkg::VALUE_W-1:0]   o_head
);
    import sil_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] r_entry [CAPACITY];
    logic signed [VALUE_W-1:0] n_entry [CAPACITY];
    logic        [CAPACITY-1:0] w_gt;
    logic        [CW-1:0]       r_count;
    logic        [CW-1:0]       n_count;

    // A valid entry greater than the new value moves up one place.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign w_gt[i] = (CW'(i) < r_count) && (r_entry[i] > i_value);

        always_comb begin
            n_entry[i] = r_entry[i];
            if (i_cmd.insert) begin
                if (i > 0 && w_gt[(i > 0) ? i - 1 : 0]) begin
                    n_entry[i] = r_entry[(i > 0) ? i - 1 : 0];
                end else if (w_gt[i] || CW'(i) == r_count) begin
                    n_entry[i] = i_value;
                end
            end else if (i_cmd.rotate) begin
                if (CW'(i) + CW'(1) == r_count) begin
                    n_entry[i] = r_entry[0];
                end else if (i < CAPACITY - 1) begin
                    n_entry[i] = r_entry[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_entry[i] <= n_entry[i];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.insert) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_head  = r_entry[0];

endmodule

>>> rtl/sil_ctrl.sv
// Controller of the sorted insert list: accept, then list one entry per cycle while the sink is ready.
`timescale 1ns / 1ps

module sil_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic [$clog2(CAPACITY+1)-1:0]     i_count,
    output sil_pkg::t_dp_cmd                  o_cmd,
    output logic [sil_pkg::POS_W-1:0]         o_position,
    output logic                              o_last,
    output logic                              o_dropped
);
    import sil_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    logic          r_state;
    logic          n_state;
    logic [IW-1:0] r_pos;
    logic [IW-1:0] n_pos;
    logic          r_drop;
    logic          n_drop;
    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_full;

    assign w_full    = (i_count == CW'(CAPACITY));
    assign w_in_acc  = i_in_valid && (r_state == ST_IDLE);
    assign w_out_acc = i_out_ready && (r_state == ST_LIST);
    assign o_last    = (CW'(r_pos) + CW'(1) == i_count);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_drop  = r_drop;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_LIST;
                    n_pos   = '0;
                    n_drop  = w_full;
                end
            end
            ST_LIST: begin
                if (w_out_acc) begin
                    if (o_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos = r_pos + IW'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_drop  <= n_drop;
        end
    end

    assign o_cmd.insert = w_in_acc && !w_full;
    assign o_cmd.rotate = w_out_acc;
    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = (r_state == ST_LIST);
    assign o_position   = POS_W'(r_pos);
    assign o_dropped    = r_drop;

endmodule

>>> rtl/sorted_insert_list_core.sv
// Top level of the sorted insert list: controller plus entry row.
`timescale 1ns / 1ps
// The first result of a listing is shown in the cycle after the item is accepted.
// Flow: the item is accepted and inserted while idle; its listing then gives one result
//   per cycle while the sink is ready, set by the entry row rotating one place for each
//   result taken. No new item is taken until the listing is done.
// Reset (synchronous, active low) empties the list and returns to idle; entry contents
//   are not cleared, only entries below the count are ever shown.

module sorted_insert_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input item channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [sil_pkg::VALUE_W-1:0]   i_new_value,
    // result item channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [sil_pkg::VALUE_W-1:0]   o_entry_value,
    output logic [sil_pkg::POS_W-1:0]            o_position,
    output logic                                 o_last,
    output logic                                 o_dropped
);
    import sil_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_dp_cmd     w_cmd;
    logic [CW-1:0] w_count;

    // Controller: takes an item only while idle, then walks the list. A full
    // list turns the insert into a drop and flags every result of that listing.
    sil_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_count     (w_count),
        .o_cmd       (w_cmd),
        .o_position  (o_position),
        .o_last      (o_last),
        .o_dropped   (o_dropped)
    );

    // Entry row: each cell decides locally whether to hold, take the new value
    // or take its lower neighbor, so the insert finishes in the accept cycle.
    // During listing the head leaves at entry 0 and wraps to the list tail;
    // after n results the row is back in sorted order.
    sil_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_value (i_new_value),
        .o_count (w_count),
        .o_head  (o_entry_value)
    );

endmodule

>>> rtl/sil_checker.sv
// Port-level checker for the sorted insert list, bound to the top level.
`timescale 1ns / 1ps

module sil_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_position,
    input logic        o_last,
    input logic        o_dropped
);

    // One item at a time: never take input while a listing is shown.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while results pending");

    // A listing starts at position zero right after the item is taken.
    a_list_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (o_out_valid && o_position == 6'd0))
        else $error("listing did not start at position zero");

    // Positions advance by one within a listing.
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=>
        (o_out_valid && o_position == 6'($past(o_position) + 6'd1)))
        else $error("position did not advance by one");

    // The dropped flag is constant over a listing.
    a_drop_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> $stable(o_dropped))
        else $error("dropped flag changed inside a listing");

    // After the final result the block is ready for the next item.
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("not ready after the final result");

endmodule

bind sorted_insert_list_core sil_checker u_sil_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_position  (o_position),
    .o_last      (o_last),
    .o_dropped   (o_dropped)
);

>>> dv/sorted_insert_list_core_tb.sv
// Self-checking testbench for sorted_insert_list_core: sorted-list prediction and listing check.
`timescale 1ns / 1ps

module sorted_insert_list_core_tb;

    import sil_pkg::*;

    localparam int LIST_DEPTH     = 16;
    localparam int RANDOM_ITEMS   = 362;
    localparam int ITEMS_PER_LEG  = 30;     // items per idling phase before moving on
    localparam int DRAIN_CYCLES   = LIST_DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic signed [VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    // Idling phases, stepped through in turn as items go out.
    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SRC_GAPS,
        PH_SINK_STALLS,
        PH_BOTH_IDLE
    } t_idle_phase;

    // One listed entry as the block should present it.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          pos;
        logic                      last;
        logic                      dropped;
    } t_listed_entry;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_ready;
    logic signed [VALUE_W-1:0] i_new_value  = '0;
    logic                      o_out_valid;
    logic                      i_out_ready  = 1'b0;
    logic signed [VALUE_W-1:0] o_entry_value;
    logic [POS_W-1:0]          o_position;
    logic                      o_last;
    logic                      o_dropped;

    sorted_insert_list_core #(
        .CAPACITY (LIST_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_new_value   (i_new_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_entry_value (o_entry_value),
        .o_position    (o_position),
        .o_last        (o_last),
        .o_dropped     (o_dropped)
    );

    always #5 i_clk = ~i_clk;

    // Values still to be sent, and listing entries still to be seen.
    logic signed [VALUE_W-1:0] pending_values [$];
    t_listed_entry             expected_listing [$];

    // Predicted contents of the list.
    logic signed [VALUE_W-1:0] sorted_vals [LIST_DEPTH];
    int unsigned               sorted_len = 0;

    int unsigned items_sent      = 0;
    int unsigned inserts_seen    = 0;
    int unsigned refusals_seen   = 0;
    int unsigned entries_checked = 0;
    int unsigned fail_count      = 0;
    int unsigned quiet_cycles    = 0;

    logic        in_taken_q  = 1'b0;
    t_idle_phase idle_phase;

    assign idle_phase = t_idle_phase'((items_sent / ITEMS_PER_LEG) % 4);

    // Insert after every entry <= value, or refuse when full, then queue the full listing.
    task automatic predict_listing(input logic signed [VALUE_W-1:0] value);
        int unsigned   slot;
        logic          refused;
        t_listed_entry entry;
        refused = (sorted_len >= LIST_DEPTH);
        if (refused) begin
            refusals_seen++;
        end else begin
            slot = 0;
            while (slot < sorted_len && sorted_vals[slot] <= value) slot++;
            for (int unsigned k = sorted_len; k > slot; k--) sorted_vals[k] = sorted_vals[k - 1];
            sorted_vals[slot] = value;
            sorted_len++;
            inserts_seen++;
        end
        for (int unsigned k = 0; k < sorted_len; k++) begin
            entry.value   = sorted_vals[k];
            entry.pos     = POS_W'(k);
            entry.last    = (k + 1 == sorted_len);
            entry.dropped = refused;
            expected_listing.push_back(entry);
        end
    endtask

    // Input side: record acceptance and predict on the same edge.
    always @(posedge i_clk) begin
        in_taken_q <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_listing(i_new_value);
        end
    end

    // Driver: hold the item until taken, then load the next one or idle.
    always @(negedge i_clk) begin
        logic src_idle;
        logic sink_stall;
        src_idle   = 1'b0;
        sink_stall = 1'b0;
        case (idle_phase)
            PH_SRC_GAPS: begin
                src_idle = ($urandom_range(99) < 48);
            end
            PH_SINK_STALLS: begin
                sink_stall = ($urandom_range(99) < 48);
            end
            PH_BOTH_IDLE: begin
                src_idle   = ($urandom_range(99) < 11);
                sink_stall = ($urandom_range(99) < 11);
            end
            default: begin
            end
        endcase
        i_out_ready <= i_rst_n && !sink_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken_q) begin
            if (pending_values.size() > 0 && !src_idle) begin
                i_new_value <= pending_values.pop_front();
                i_in_valid  <= 1'b1;
                items_sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each taken result with the oldest expected entry.
    always @(posedge i_clk) begin
        t_listed_entry want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_listing.size() == 0) begin
                $error("unexpected result: value %0d position %0d", o_entry_value, o_position);
                fail_count++;
            end else begin
                want = expected_listing.pop_front();
                entries_checked++;
                if (o_entry_value !== want.value) begin
                    $error("entry_value: expected %0d, got %0d", want.value, o_entry_value);
                    fail_count++;
                end
                if (o_position !== want.pos) begin
                    $error("position: expected %0d, got %0d", want.pos, o_position);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    fail_count++;
                end
                if (o_dropped !== want.dropped) begin
                    $error("dropped: expected %0b, got %0b", want.dropped, o_dropped);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("sorted_insert_list_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic signed [VALUE_W-1:0] dup_value;
        dup_value = $urandom;
        // Fill the list: extremes, sign boundary, alternating bits and repeats.
        pending_values.push_back(32'sd0);
        pending_values.push_back(MOST_NEG);
        pending_values.push_back(MOST_POS);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'sd1);
        pending_values.push_back(32'sd0);
        pending_values.push_back(MOST_POS);
        pending_values.push_back(MOST_NEG);
        pending_values.push_back(32'sh5555_5555);
        pending_values.push_back(32'shAAAA_AAAA);
        pending_values.push_back(-32'sd2);
        pending_values.push_back(dup_value);
        pending_values.push_back(dup_value);
        pending_values.push_back($urandom);
        pending_values.push_back($urandom);
        pending_values.push_back($urandom);
        // The list is full now: these are refused and relisted.
        pending_values.push_back(MOST_POS);
        pending_values.push_back(MOST_NEG);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(3))
                0:       pending_values.push_back($signed(32'($urandom_range(15))) - 32'sd8);
                1:       pending_values.push_back(($urandom_range(1) != 0) ? MOST_POS : MOST_NEG);
                default: pending_values.push_back($urandom);
            endcase
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_values.size() > 0 || i_in_valid || expected_listing.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_listing.size() > 0) begin
            $error("%0d expected results never arrived", expected_listing.size());
            fail_count++;
        end
        $display("Sent %0d items: %0d placed in the list, %0d refused on a full list.",
                 items_sent, inserts_seen, refusals_seen);
        $display("Checked %0d listed entries across all idling phases.", entries_checked);
        if (fail_count == 0) begin
            $display("sorted_insert_list_core: match");
        end else begin
            $display("sorted_insert_list_core: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sil_pkg.sv
rtl/sil_datapath.sv
rtl/sil_ctrl.sv
rtl/sorted_insert_list_core.sv
rtl/sil_checker.sv
dv/sorted_insert_list_core_tb.sv
